FILE: src/skf_pkg.sv
// Shared types and constants for the scalar Kalman filter.
// No dependencies; imported by skf_ctrl, skf_dp and scalar_kalman_filter.
`timescale 1ns / 1ps

package skf_pkg;

  // Fixed field widths of the channels
  localparam int MEAS_W     = 16;   // measurement, signed integer
  localparam int DATA_W     = 32;   // estimate / variance / noise, Q16.16
  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_IDX_W  = 8;

  // Default format parameters
  localparam int FRAC_BITS_DEF   = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  // Gain format: unsigned, 16 fraction bits, range 0 .. 1.0
  localparam int GAIN_BITS = 16;
  localparam int GAIN_W    = GAIN_BITS + 1;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;

  // One quotient bit per step: integer bit plus GAIN_BITS fraction bits
  localparam int DIV_STEPS = GAIN_BITS + 1;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Shared multiplier: 33-bit magnitude by 17-bit gain
  localparam int MUL_A_W = DATA_W + 1;
  localparam int PROD_W  = MUL_A_W + GAIN_W;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = CFG_IDX_W'(1);

  // Register reset values: Q = 20.0, R = 200.0
  localparam logic [DATA_W-1:0] PROC_NOISE_RST = 32'd1310720;
  localparam logic [DATA_W-1:0] MEAS_NOISE_RST = 32'd13107200;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture and scale a new sample
    logic pred;      // predicted variance and innovation
    logic den;       // denominator, innovation magnitude, divider init
    logic div_step;  // one restoring division step
    logic mul_est;   // innovation magnitude times gain
    logic mul_var;   // (1 - gain) times predicted variance
    logic commit;    // update state, result becomes visible
  } skf_cmd_t;

endpackage

FILE: src/scalar_kalman_filter.sv
// Top level of the scalar Kalman filter.
// Depends on skf_pkg, skf_ctrl and skf_dp.
//
//  Channel  Direction  Handshake              Payload
//  in_      slave      in_tvalid / in_tready    in_tdata[15:0]  measurement
//  out_     master     out_tvalid / out_tready  out_tdata[31:0] estimate,
//                                               out_tdata[63:32] error_variance
//  cfg_     slave      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Each sample is accepted only in idle and then passes through the setup states
// ST_PRED and ST_DEN, the bit-serial gain divider in ST_DIV, the shared multiplier
// in ST_MULE and ST_MULV, and ST_FIN to commit. A new sample is taken while the last
// result still waits; a stalled output holds the commit of the following one.
// Synchronous active-low reset clears estimate and variance to zero and loads
// the default noise values. Configuration writes are always taken.
`timescale 1ns / 1ps

module scalar_kalman_filter import skf_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input transaction
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,    // [15:0] measurement
  // result transaction
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,   // [31:0] estimate, [63:32] error_variance
  // configuration write
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DATA_W-1:0]      cfg_data
);

  skf_cmd_t           cmd;
  logic [DATA_W-1:0]  estimate;
  logic [DATA_W-1:0]  error_variance;

  assign cfg_ready = 1'b1;
  assign out_tdata = {error_variance, estimate};

  skf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  skf_dp #(
    .FRAC_BITS   (FRAC_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .measurement    (in_tdata[MEAS_W-1:0]),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .estimate       (estimate),
    .error_variance (error_variance)
  );

endmodule

FILE: src/skf_ctrl.sv
// Sequencer of the scalar Kalman filter: accept, predict, divide, multiply, commit.
// Depends on skf_pkg; drives skf_dp through skf_cmd_t.
`timescale 1ns / 1ps

module skf_ctrl import skf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output skf_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_DEN,
    ST_DIV,
    ST_MULE,
    ST_MULV,
    ST_FIN
  } state_t;

  state_t                 state_r, state_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   commit;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  // Result register must be free (or emptying) before the state updates
  assign commit = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  // Command decode
  always_comb begin
    cmd          = '0;
    cmd.load     = in_tvalid && (state_r == ST_IDLE);
    cmd.pred     = (state_r == ST_PRED);
    cmd.den      = (state_r == ST_DEN);
    cmd.div_step = (state_r == ST_DIV);
    cmd.mul_est  = (state_r == ST_MULE);
    cmd.mul_var  = (state_r == ST_MULV);
    cmd.commit   = commit;
  end

  // Next state
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_PRED;
        end
      end
      ST_PRED: state_nxt = ST_DEN;
      ST_DEN: begin
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_MULE;
        end
      end
      ST_MULE: state_nxt = ST_MULV;
      ST_MULV: state_nxt = ST_FIN;
      ST_FIN: begin
        if (commit) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: src/skf_dp.sv
// Datapath of the scalar Kalman filter: noise registers, filter state,
// serial gain divider and one shared multiplier. Depends on skf_pkg.
`timescale 1ns / 1ps

module skf_dp import skf_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  skf_cmd_t             cmd,
  input  logic [MEAS_W-1:0]    measurement,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  output logic [DATA_W-1:0]    estimate,
  output logic [DATA_W-1:0]    error_variance
);

  localparam int SW = (SAMPLE_BITS > MEAS_W) ? SAMPLE_BITS : MEAS_W;
  localparam int MW = (SAMPLE_BITS + FRAC_BITS > DATA_W + 1) ?
                      SAMPLE_BITS + FRAC_BITS : DATA_W + 1;
  localparam logic signed [MW-1:0] Z_MAX = MW'(signed'(33'h0_7FFF_FFFF));
  localparam logic signed [MW-1:0] Z_MIN = MW'(signed'(33'h1_8000_0000));
  localparam logic [PROD_W-1:0]    HALF  = PROD_W'(1) << (GAIN_BITS - 1);

  // Configuration and filter state
  logic [DATA_W-1:0]  proc_noise_r, meas_noise_r;
  logic [DATA_W-1:0]  est_r, est_nxt;
  logic [DATA_W-1:0]  var_r, var_nxt;

  // Per-item working registers
  logic [DATA_W-1:0]  z_r;
  logic [DATA_W-1:0]  p_r;
  logic [DATA_W:0]    diff_r;
  logic [DATA_W:0]    den_r;
  logic [DATA_W:0]    mag_r;
  logic               neg_r;
  logic [DATA_W+1:0]  rem_r;
  logic [GAIN_W-1:0]  gain_r;
  logic [PROD_W-1:0]  prod_r;
  logic [DATA_W-1:0]  step_r;

  // Sample scaling with saturation to the signed 32-bit range
  logic [SW-1:0]                  meas_ext;
  logic signed [SAMPLE_BITS-1:0]  smp;
  logic signed [MW-1:0]           z_wide;
  logic [DATA_W-1:0]              z_sat;

  assign meas_ext = SW'(measurement);
  assign smp      = meas_ext[SAMPLE_BITS-1:0];
  assign z_wide   = MW'(smp) <<< FRAC_BITS;

  always_comb begin
    if (z_wide > Z_MAX) begin
      z_sat = 32'h7FFF_FFFF;
    end else if (z_wide < Z_MIN) begin
      z_sat = 32'h8000_0000;
    end else begin
      z_sat = z_wide[DATA_W-1:0];
    end
  end

  // Predicted variance, saturating
  logic [DATA_W:0]    p_sum;
  logic [DATA_W-1:0]  p_sat;
  assign p_sum = {1'b0, var_r} + {1'b0, proc_noise_r};
  assign p_sat = p_sum[DATA_W] ? '1 : p_sum[DATA_W-1:0];

  // Restoring division step
  logic [DATA_W+2:0]  trial;
  logic               q_bit;
  logic [DATA_W+1:0]  rem_keep;
  assign trial    = {1'b0, rem_r} - {2'b00, den_r};
  assign q_bit    = !trial[DATA_W+2];
  assign rem_keep = q_bit ? trial[DATA_W+1:0] : rem_r;

  // Gain is zero when the denominator is zero
  logic [GAIN_W-1:0]  gain_eff;
  assign gain_eff = (den_r == '0) ? '0 : gain_r;

  // Shared multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [GAIN_W-1:0]  mul_b;
  always_comb begin
    if (cmd.mul_var) begin
      mul_a = {1'b0, p_r};
      mul_b = GAIN_ONE - gain_eff;
    end else begin
      mul_a = mag_r;
      mul_b = gain_eff;
    end
  end

  // Round to nearest on the product
  logic [PROD_W-1:0]  prod_rnd;
  assign prod_rnd = prod_r + HALF;

  // New state; estimate always lies between old estimate and sample
  assign est_nxt = neg_r ? (est_r - step_r) : (est_r + step_r);
  assign var_nxt = prod_rnd[GAIN_BITS +: DATA_W];

  // Configuration and filter state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proc_noise_r <= PROC_NOISE_RST;
      meas_noise_r <= MEAS_NOISE_RST;
      est_r        <= '0;
      var_r        <= '0;
    end else begin
      if (cfg_we && (cfg_index == CFG_PROC_NOISE)) begin
        proc_noise_r <= cfg_data;
      end
      if (cfg_we && (cfg_index == CFG_MEAS_NOISE)) begin
        meas_noise_r <= cfg_data;
      end
      if (cmd.commit) begin
        est_r <= est_nxt;
        var_r <= var_nxt;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      z_r <= z_sat;
    end
    if (cmd.pred) begin
      p_r    <= p_sat;
      diff_r <= {z_r[DATA_W-1], z_r} - {est_r[DATA_W-1], est_r};
    end
    if (cmd.den) begin
      den_r  <= {1'b0, p_r} + {1'b0, meas_noise_r};
      neg_r  <= diff_r[DATA_W];
      mag_r  <= diff_r[DATA_W] ? (~diff_r + (DATA_W + 1)'(1)) : diff_r;
      rem_r  <= {2'b00, p_r};
      gain_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r  <= {rem_keep[DATA_W:0], 1'b0};
      gain_r <= {gain_r[GAIN_W-2:0], q_bit};
    end
    if (cmd.mul_est || cmd.mul_var) begin
      prod_r <= PROD_W'(mul_a * mul_b);
    end
    if (cmd.mul_var) begin
      step_r <= prod_rnd[GAIN_BITS +: DATA_W];
    end
  end

  assign estimate       = est_r;
  assign error_variance = var_r;

endmodule

FILE: sim/scalar_kalman_filter_test.sv
// Self-checking testbench for scalar_kalman_filter: directed and random samples under
// several noise settings, with a predictor of its own and a scoreboard on the result stream.
// Depends on skf_pkg and the scalar_kalman_filter RTL.
`timescale 1ns / 1ps

module scalar_kalman_filter_test;
  import skf_pkg::*;

  // Index with no register behind it; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX = CFG_IDX_W'(255);
  localparam int FRAC_W   = FRAC_BITS_DEF;
  localparam int SAMPLE_W = SAMPLE_BITS_DEF;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_SAMPLES = 104;

  typedef struct packed {
    logic [DATA_W-1:0] variance;
    logic [DATA_W-1:0] estimate;
  } filter_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [DATA_W-1:0]      cfg_data = '0;

  // Predictor copy of filter state and noise registers
  logic signed [DATA_W-1:0] filt_estimate;
  logic [DATA_W-1:0]        filt_variance;
  logic [DATA_W-1:0]        noise_q = PROC_NOISE_RST;
  logic [DATA_W-1:0]        noise_r = MEAS_NOISE_RST;

  logic [MEAS_W-1:0] pending_samples[$];
  filter_result_t    expected_results[$];
  int                mismatches = 0;
  int                cycle_count = 0;
  logic              steady;

  scalar_kalman_filter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Long window with no gaps on either side
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end
  assign steady = (cycle_count >= 4000) && (cycle_count < 10000);

  // One filter update: predict variance, gain, move estimate, shrink variance
  function automatic filter_result_t kalman_update(input logic [MEAS_W-1:0] sample);
    longint         z;
    longint         x;
    longint         diff;
    longint         x_next;
    logic [63:0]    p;
    logic [63:0]    den;
    logic [63:0]    gain;
    logic [63:0]    mag;
    logic [63:0]    step;
    logic [63:0]    p_next;
    filter_result_t res;
    z = longint'($signed(sample[SAMPLE_W-1:0])) * (longint'(1) << FRAC_W);
    if (z > longint'(32'sh7FFF_FFFF)) z = longint'(32'sh7FFF_FFFF);
    if (z < -(longint'(1) << 31)) z = -(longint'(1) << 31);
    x = longint'(filt_estimate);
    p = {32'd0, filt_variance} + {32'd0, noise_q};
    if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
    den = p + {32'd0, noise_r};
    gain = (den != 64'd0) ? (p << GAIN_BITS) / den : 64'd0;
    diff = z - x;
    mag = (diff < 0) ? -diff : diff;
    step = (mag * gain + (64'd1 << (GAIN_BITS - 1))) >> GAIN_BITS;
    x_next = (diff < 0) ? x - longint'(step) : x + longint'(step);
    p_next = (((64'd1 << GAIN_BITS) - gain) * p + (64'd1 << (GAIN_BITS - 1))) >> GAIN_BITS;
    filt_estimate = x_next[DATA_W-1:0];
    filt_variance = p_next[DATA_W-1:0];
    res.estimate = filt_estimate;
    res.variance = filt_variance;
    return res;
  endfunction

  // Sample driver: predicts on each accepted transaction, then loads the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      filt_estimate <= '0;
      filt_variance <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(kalman_update(in_tdata));
      end
      if (!in_tvalid || in_tready) begin
        if (pending_samples.size() != 0 && (steady || $urandom_range(0, 99) >= 16)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_samples.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random backpressure and scoreboard check
  always @(posedge clk) begin
    filter_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(0, 99) >= 16);
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result estimate=%h variance=%h", $time,
                   out_tdata[31:0], out_tdata[63:32]);
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[31:0] !== want.estimate) begin
            mismatches++;
            $display("%0t: estimate expected %h actual %h", $time,
                     want.estimate, out_tdata[31:0]);
          end
          if (out_tdata[63:32] !== want.variance) begin
            mismatches++;
            $display("%0t: error_variance expected %h actual %h", $time,
                     want.variance, out_tdata[63:32]);
          end
        end
      end
    end
  end

  // Register write transaction; predictor copy follows the same decode
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_PROC_NOISE) noise_q = value;
    else if (idx == CFG_MEAS_NOISE) noise_r = value;
  endtask

  // Block is idle once every sample is in and every result is out
  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_noise();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(0, 32'h00FF_FFFF);
      3:       return $urandom;
      default: return $urandom_range(1, 32'h0040_0000);
    endcase
  endfunction

  initial begin
    logic signed [MEAS_W-1:0] level;
    logic signed [MEAS_W-1:0] sample;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset noise values: extremes and alternating bit patterns
    pending_samples = '{16'h0000, 16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA,
                        16'hFFFF, 16'h0001, 16'h0000};
    wait_idle();

    // Q = R = 0: gain of one, then a zero denominator keeps the estimate
    write_reg(CFG_PROC_NOISE, '0);
    write_reg(CFG_MEAS_NOISE, '0);
    pending_samples = '{16'h1234, 16'h8000, 16'h7FFF};
    wait_idle();

    // Huge Q saturates the predicted variance
    write_reg(CFG_PROC_NOISE, '1);
    pending_samples = '{16'h7FFF, 16'h8000, 16'h0000};
    wait_idle();

    write_reg(CFG_MEAS_NOISE, '1);
    pending_samples = '{16'h8000, 16'h7FFF, 16'h0100};
    wait_idle();

    // Writes to unmapped indexes must not disturb Q or R
    write_reg(CFG_PROC_NOISE, '0);
    write_reg(CFG_NO_REG, 32'h0000_0001);
    write_reg(CFG_TOP_IDX, '0);
    pending_samples = '{16'h0001, 16'hFFFF, 16'h7FFF};
    wait_idle();

    // Random noise settings, a drifting sensor level with noise and occasional outliers
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) begin
        write_reg(CFG_PROC_NOISE, PROC_NOISE_RST);
        write_reg(CFG_MEAS_NOISE, MEAS_NOISE_RST);
      end else begin
        write_reg(CFG_PROC_NOISE, pick_noise());
        write_reg(CFG_MEAS_NOISE, pick_noise());
        if ($urandom_range(0, 3) == 0) write_reg(CFG_IDX_W'($urandom_range(2, 255)), $urandom);
      end
      level = MEAS_W'($urandom);
      for (int i = 0; i < PHASE_SAMPLES; i++) begin
        case ($urandom_range(0, 9))
          0:       sample = MEAS_W'($urandom);
          1:       sample = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
          default: begin
            level  = level + $signed(16'($urandom_range(0, 64))) - 16'sd32;
            sample = level + $signed(16'($urandom_range(0, 400))) - 16'sd200;
          end
        endcase
        pending_samples.push_back(sample);
      end
      wait_idle();
    end

    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
